// File: sv/mhtq_pkg.sv
// Package for the min-heap timer queue: operation and status codes, field widths.
// No dependencies.
package mhtq_pkg;

  localparam int CAPACITY_DEF = 32;
  localparam int ID_SPACE_DEF = 256;
  localparam int MaxResults   = 32;
  localparam int KIND_W   = 3;
  localparam int ID_W     = 8;
  localparam int TO_W     = 24;
  localparam int EXP_W    = 32;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 6;
  localparam logic [TO_W-1:0] WAIT_MAX = '1;

  typedef enum logic [KIND_W-1:0] {
    KIND_ADD    = 3'd0,
    KIND_ADJUST = 3'd1,
    KIND_POP    = 3'd2,
    KIND_CLEAR  = 3'd3,
    KIND_TICK   = 3'd4
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_UNKNOWN = 2'd1,
    ST_FULL    = 2'd2,
    ST_EMPTY   = 2'd3
  } status_t;

  // True when expiry a is strictly earlier than b, wrap-aware.
  function automatic logic earlier(input logic [EXP_W-1:0] a, input logic [EXP_W-1:0] b);
    logic [EXP_W-1:0] d;
    d = a - b;
    return d[EXP_W-1];
  endfunction

endpackage

// File: sv/mhtq_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module mhtq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// File: sv/min_heap_timeout_queue_core.sv
// Top level of the min-heap timer queue: sequencer, heap and slot-map memories.
// Depends on mhtq_pkg and mhtq_ram.
//
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  input   | valid/stall, kind, entry_id, timeout_ms   | in
//  output  | out_valid/out_stall, out_id .. last       | out
//
// One item is processed at a time; stall is high while the sequencer is busy.
// Each sift-up level reads the parent, then compares and moves; each sift-down
// level reads the two children, then compares and moves. An add, refresh or pop
// sifts its entry up or down as needed before the result step; clear, a rejected
// item or a tick with nothing due needs no sift and goes on to the result step.
// A tick repeats the pop sequence for every timer that fires.
// Reset clears the present bits, count and time; the memories are never cleared.
// A result waiting under out_stall holds the result step, and with it the input.
module min_heap_timeout_queue_core
  import mhtq_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF,
  parameter int ID_SPACE = ID_SPACE_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           valid,
  output logic                           stall,
  input  logic [mhtq_pkg::KIND_W-1:0]    kind,
  input  logic [mhtq_pkg::ID_W-1:0]      entry_id,
  input  logic [mhtq_pkg::TO_W-1:0]      timeout_ms,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [mhtq_pkg::ID_W-1:0]      out_id,
  output logic                           id_valid,
  output logic                           fired,
  output logic [mhtq_pkg::STATUS_W-1:0]  status,
  output logic [mhtq_pkg::TO_W-1:0]      next_wait_ms,
  output logic                           queue_empty,
  output logic [mhtq_pkg::COUNT_W-1:0]   entry_count,
  output logic                           last
);
  localparam int SW = $clog2(CAPACITY);
  localparam int LW = SW + 1;
  localparam int IW = $clog2(ID_SPACE);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int NW = $clog2(MaxResults + 1);
  localparam int HW = ID_W + EXP_W;

  typedef enum logic [13:0] {
    S_IDLE   = 14'b00000000000001,
    S_LOOK   = 14'b00000000000010,
    S_TICKCK = 14'b00000000000100,
    S_REMOVE = 14'b00000000001000,
    S_RMLAST = 14'b00000000010000,
    S_UP     = 14'b00000000100000,
    S_UPCMP  = 14'b00000001000000,
    S_DNRD   = 14'b00000010000000,
    S_DNRR   = 14'b00000100000000,
    S_DNCMP  = 14'b00001000000000,
    S_PLACE  = 14'b00010000000000,
    S_EMIT   = 14'b00100000000000,
    S_SPARE0 = 14'b01000000000000,
    S_SPARE1 = 14'b10000000000000
  } state_t;

  state_t state;
  logic [KIND_W-1:0] op;
  logic [IW-1:0] op_id;
  logic [EXP_W-1:0] op_exp;
  logic [CW-1:0] count;
  logic [EXP_W-1:0] now;
  logic [ID_SPACE-1:0] present;
  logic [NW-1:0] nres;
  logic [SW-1:0] cur;
  logic [HW-1:0] cur_e, lft_e, root_e;
  logic up_moved;
  logic [ID_W-1:0] r_id;
  logic r_valid, r_fired;
  logic [STATUS_W-1:0] r_status;

  // Heap memory (id and expiry) and slot map.
  logic          h_we;
  logic [SW-1:0] h_wa, h_ra;
  logic [HW-1:0] h_wd, h_rd;
  logic          m_we;
  logic [IW-1:0] m_wa, m_ra;
  logic [SW-1:0] m_wd, m_rd;

  mhtq_ram #(.WIDTH(HW), .DEPTH(CAPACITY)) u_heap (
    .clk(clk), .we(h_we), .waddr(h_wa), .wdata(h_wd), .raddr(h_ra), .rdata(h_rd));
  mhtq_ram #(.WIDTH(SW), .DEPTH(ID_SPACE)) u_slot (
    .clk(clk), .we(m_we), .waddr(m_wa), .wdata(m_wd), .raddr(m_ra), .rdata(m_rd));

  assign stall = (state != S_IDLE);

  // The slot map is read at the accepting edge so that it is ready in S_LOOK.
  assign m_ra = (state == S_IDLE) ? IW'(entry_id) : op_id;

  // Index arithmetic for the current hole.
  logic [LW-1:0] lidx;
  logic [SW-1:0] par;
  assign lidx = {cur, 1'b1};
  assign par  = (cur - SW'(1)) >> 1;

  // Child selection and move decisions.
  logic          pick_right, up_go, dn_go;
  logic [HW-1:0] child_e;
  logic [SW-1:0] child_i;
  assign pick_right = ((lidx + LW'(1)) < LW'(count))
                      && earlier(h_rd[EXP_W-1:0], lft_e[EXP_W-1:0]);
  assign child_e = pick_right ? h_rd : lft_e;
  assign child_i = pick_right ? SW'(lidx + LW'(1)) : lidx[SW-1:0];
  assign up_go   = earlier(cur_e[EXP_W-1:0], h_rd[EXP_W-1:0]);
  assign dn_go   = earlier(child_e[EXP_W-1:0], cur_e[EXP_W-1:0]);

  // Root state after the step: due test, wait and tick continuation.
  logic [EXP_W-1:0] root_d;
  logic             root_due, more, emit_go;
  logic [TO_W-1:0]  wait_ms;
  assign root_d   = root_e[EXP_W-1:0] - now;
  assign root_due = (count != '0) && ((root_d == '0) || root_d[EXP_W-1]);
  assign more     = (op == KIND_TICK) && r_fired && root_due
                    && (nres != NW'(MaxResults - 1));
  assign emit_go  = (state == S_EMIT) && (!out_valid || !out_stall);
  assign wait_ms  = (count == '0 || root_d[EXP_W-1]) ? '0
                  : (|root_d[EXP_W-1:TO_W]) ? WAIT_MAX : root_d[TO_W-1:0];

  // Heap memory and slot map address and write control.
  always_comb begin
    h_we = 1'b0; h_wa = cur; h_wd = cur_e; h_ra = cur;
    m_we = 1'b0; m_wa = IW'(cur_e[HW-1 -: ID_W]); m_wd = cur;
    case (state)
      S_UP:     h_ra = par;
      S_DNRD:   h_ra = lidx[SW-1:0];
      S_DNRR:   h_ra = SW'(lidx + LW'(1));
      S_REMOVE: h_ra = SW'(count - CW'(1));
      S_UPCMP: begin
        // The parent moves down into the hole.
        if (up_go) begin
          h_we = 1'b1; h_wd = h_rd;
          m_we = 1'b1; m_wa = IW'(h_rd[HW-1 -: ID_W]);
        end
      end
      S_DNCMP: begin
        // The earlier child moves up into the hole.
        if (dn_go) begin
          h_we = 1'b1; h_wd = child_e;
          m_we = 1'b1; m_wa = IW'(child_e[HW-1 -: ID_W]);
        end
      end
      S_PLACE: begin
        h_we = 1'b1;
        m_we = 1'b1;
      end
      default: ;
    endcase
  end

  // Shadow of heap slot zero, kept in step with every write to it.
  always_ff @(posedge clk) begin
    if (h_we && h_wa == '0) root_e <= h_wd;
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE; count <= '0; now <= '0; present <= '0; nres <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (valid && !stall) begin
            op <= kind; op_id <= IW'(entry_id); op_exp <= now + EXP_W'(timeout_ms);
            nres <= '0;
            r_id <= '0; r_valid <= 1'b0; r_fired <= 1'b0;
            r_status <= (kind == KIND_POP && count == '0) ? ST_EMPTY : ST_OK;
            case (kind)
              KIND_ADD, KIND_ADJUST: state <= S_LOOK;
              KIND_POP: state <= (count == '0) ? S_EMIT : S_REMOVE;
              KIND_CLEAR: begin
                present <= '0; count <= '0; state <= S_EMIT;
              end
              KIND_TICK: begin
                now <= now + EXP_W'(1); state <= S_TICKCK;
              end
              default: state <= S_EMIT;
            endcase
          end
        end
        S_LOOK: begin
          // Slot map data for op_id is valid in this cycle.
          if (present[op_id]) begin
            cur <= m_rd; cur_e <= {ID_W'(op_id), op_exp}; up_moved <= 1'b0;
            state <= S_UP;
          end else if (op == KIND_ADJUST) begin
            r_status <= ST_UNKNOWN; state <= S_EMIT;
          end else if (count >= CW'(CAPACITY)) begin
            r_status <= ST_FULL; state <= S_EMIT;
          end else begin
            cur <= SW'(count); cur_e <= {ID_W'(op_id), op_exp};
            present[op_id] <= 1'b1; count <= count + CW'(1);
            up_moved <= 1'b0; state <= S_UP;
          end
        end
        S_TICKCK: state <= root_due ? S_REMOVE : S_EMIT;
        S_REMOVE: begin
          // Take the root out; the last entry refills slot zero.
          r_id <= root_e[HW-1 -: ID_W]; r_valid <= 1'b1;
          r_fired <= (op == KIND_TICK); r_status <= ST_OK;
          present[IW'(root_e[HW-1 -: ID_W])] <= 1'b0;
          count <= count - CW'(1);
          state <= (count == CW'(1)) ? S_EMIT : S_RMLAST;
        end
        S_RMLAST: begin
          cur <= '0; cur_e <= h_rd; state <= S_DNRD;
        end
        S_UP: begin
          if (cur == '0) state <= up_moved ? S_PLACE : S_DNRD;
          else state <= S_UPCMP;
        end
        S_UPCMP: begin
          if (up_go) begin
            cur <= par; up_moved <= 1'b1; state <= S_UP;
          end else state <= up_moved ? S_PLACE : S_DNRD;
        end
        S_DNRD: state <= (lidx >= LW'(count)) ? S_PLACE : S_DNRR;
        S_DNRR: begin
          lft_e <= h_rd; state <= S_DNCMP;
        end
        S_DNCMP: begin
          if (dn_go) begin
            cur <= child_i; state <= S_DNRD;
          end else state <= S_PLACE;
        end
        S_PLACE: state <= S_EMIT;
        S_EMIT: begin
          // A tick keeps removing while the new root is due and the result limit is not reached.
          if (emit_go) begin
            if (more) begin
              nres <= nres + NW'(1); state <= S_REMOVE;
            end else state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Result register: loaded when the slot is free or being taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= emit_go || (out_valid && out_stall);
      if (emit_go) begin
        out_id <= r_id; id_valid <= r_valid; fired <= r_fired; status <= r_status;
        next_wait_ms <= wait_ms;
        queue_empty  <= (count == '0);
        entry_count  <= COUNT_W'(count);
        last         <= !more;
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY)) else $error("heap count above capacity");
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable({out_id, id_valid, fired, status,
      next_wait_ms, queue_empty, entry_count, last}))
    else $error("result beat changed under stall");
  assert property (@(posedge clk) disable iff (rst)
    $onehot(state)) else $error("state not one-hot");
  assert property (@(posedge clk) disable iff (rst)
    out_valid && fired |-> id_valid && (status == ST_OK))
    else $error("fired beat without an id");
endmodule

// File: sim/min_heap_timeout_queue_core_tb.sv
// Self-checking testbench for min_heap_timeout_queue_core: a behavioral timer heap
// predicts every result beat, and random gaps and stalls are applied on both channels.
// Depends on mhtq_pkg and the core RTL.
`timescale 1ns / 1ps

module min_heap_timeout_queue_core_tb;
  import mhtq_pkg::*;

  localparam int CAP = 32;
  localparam int IDS = 256;
  localparam longint CYCLE_LIMIT = 3000000;

  typedef struct packed {
    logic [ID_W-1:0]     out_id;
    logic                id_valid;
    logic                fired;
    logic [STATUS_W-1:0] status;
    logic [TO_W-1:0]     next_wait_ms;
    logic                queue_empty;
    logic [COUNT_W-1:0]  entry_count;
    logic                last;
  } timer_beat_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic valid = 1'b0;
  logic stall;
  logic [KIND_W-1:0] kind = '0;
  logic [ID_W-1:0] entry_id = '0;
  logic [TO_W-1:0] timeout_ms = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [ID_W-1:0] out_id;
  logic id_valid, fired, queue_empty, last;
  logic [STATUS_W-1:0] status;
  logic [TO_W-1:0] next_wait_ms;
  logic [COUNT_W-1:0] entry_count;

  min_heap_timeout_queue_core uut (
    .clk(clk), .rst(rst), .valid(valid), .stall(stall), .kind(kind),
    .entry_id(entry_id), .timeout_ms(timeout_ms), .out_valid(out_valid),
    .out_stall(out_stall), .out_id(out_id), .id_valid(id_valid), .fired(fired),
    .status(status), .next_wait_ms(next_wait_ms), .queue_empty(queue_empty),
    .entry_count(entry_count), .last(last)
  );

  always #5 clk = ~clk;

  // Predicted timer state.
  logic [ID_W-1:0]  hp_id [CAP];
  logic [EXP_W-1:0] hp_exp [CAP];
  logic [4:0]       slot_of [IDS];
  logic             armed [IDS];
  int unsigned      n_timers;
  logic [EXP_W-1:0] clock_ms;

  timer_beat_t pending_beats[$];
  int mismatches = 0;
  longint cycles = 0;
  bit stall_busy = 1'b1;

  function automatic bit is_before(logic [EXP_W-1:0] a, logic [EXP_W-1:0] b);
    logic [EXP_W-1:0] d;
    d = a - b;
    return d[EXP_W-1];
  endfunction

  function automatic void swap_nodes(int a, int b);
    logic [ID_W-1:0] ti;
    logic [EXP_W-1:0] te;
    ti = hp_id[a]; te = hp_exp[a];
    hp_id[a] = hp_id[b]; hp_exp[a] = hp_exp[b];
    hp_id[b] = ti; hp_exp[b] = te;
    slot_of[hp_id[a]] = a[4:0];
    slot_of[hp_id[b]] = b[4:0];
  endfunction

  function automatic bit bubble_up(int i);
    bit moved;
    int p;
    moved = 1'b0;
    while (i > 0) begin
      p = (i - 1) / 2;
      if (!is_before(hp_exp[i], hp_exp[p])) break;
      swap_nodes(i, p);
      i = p;
      moved = 1'b1;
    end
    return moved;
  endfunction

  function automatic void bubble_down(int i);
    int l, c;
    forever begin
      l = 2 * i + 1;
      c = l;
      if (l >= n_timers) break;
      if (l + 1 < n_timers && is_before(hp_exp[l+1], hp_exp[l])) c = l + 1;
      if (!is_before(hp_exp[c], hp_exp[i])) break;
      swap_nodes(i, c);
      i = c;
    end
  endfunction

  function automatic void reheap(int i);
    if (!bubble_up(i)) bubble_down(i);
  endfunction

  function automatic void drop_node(int i);
    armed[hp_id[i]] = 1'b0;
    n_timers--;
    if (i != n_timers) begin
      hp_id[i] = hp_id[n_timers];
      hp_exp[i] = hp_exp[n_timers];
      slot_of[hp_id[i]] = i[4:0];
      reheap(i);
    end
  endfunction

  // Appends one expected beat, with wait and count taken from the current state.
  function automatic void push_beat(logic [ID_W-1:0] id, bit v, bit f, status_t st);
    timer_beat_t b;
    logic [EXP_W-1:0] d;
    b.out_id = id; b.id_valid = v; b.fired = f; b.status = st;
    b.next_wait_ms = '0;
    if (n_timers > 0) begin
      d = hp_exp[0] - clock_ms;
      if (d[EXP_W-1]) b.next_wait_ms = '0;
      else if (d > {8'd0, WAIT_MAX}) b.next_wait_ms = WAIT_MAX;
      else b.next_wait_ms = d[TO_W-1:0];
    end
    b.queue_empty = (n_timers == 0);
    b.entry_count = n_timers[COUNT_W-1:0];
    b.last = 1'b0;
    pending_beats = {pending_beats, b};
  endfunction

  // Advances the predicted queue by one operation and queues its result beats.
  function automatic void predict_timer_op(logic [KIND_W-1:0] k, logic [ID_W-1:0] id,
                                           logic [TO_W-1:0] to);
    int n, s;
    logic [EXP_W-1:0] d;
    n = 0;
    if (k == KIND_ADD || k == KIND_ADJUST) begin
      if (armed[id]) begin
        s = slot_of[id];
        hp_exp[s] = clock_ms + to;
        reheap(s);
        push_beat('0, 0, 0, ST_OK);
      end else if (k == KIND_ADJUST) begin
        push_beat('0, 0, 0, ST_UNKNOWN);
      end else if (n_timers >= CAP) begin
        push_beat('0, 0, 0, ST_FULL);
      end else begin
        s = n_timers;
        n_timers++;
        hp_id[s] = id; hp_exp[s] = clock_ms + to;
        slot_of[id] = s[4:0]; armed[id] = 1'b1;
        void'(bubble_up(s));
        push_beat('0, 0, 0, ST_OK);
      end
    end else if (k == KIND_POP) begin
      if (n_timers == 0) push_beat('0, 0, 0, ST_EMPTY);
      else begin
        id = hp_id[0];
        drop_node(0);
        push_beat(id, 1, 0, ST_OK);
      end
    end else if (k == KIND_CLEAR) begin
      foreach (armed[i]) armed[i] = 1'b0;
      n_timers = 0;
      push_beat('0, 0, 0, ST_OK);
    end else if (k == KIND_TICK) begin
      clock_ms++;
      while (n_timers > 0 && n < MaxResults) begin
        d = hp_exp[0] - clock_ms;
        if (d != 0 && !d[EXP_W-1]) break;
        id = hp_id[0];
        drop_node(0);
        push_beat(id, 1, 1, ST_OK);
        n++;
      end
      if (n == 0) push_beat('0, 0, 0, ST_OK);
    end else begin
      push_beat('0, 0, 0, ST_OK);
    end
    pending_beats[$].last = 1'b1;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Drives one beat into the core at the falling edge and waits for acceptance.
  // Valid stays high afterwards so that beats can follow back to back.
  task automatic send_op(logic [KIND_W-1:0] k, logic [ID_W-1:0] id, logic [TO_W-1:0] to);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    kind <= k; entry_id <= id; timeout_ms <= to; valid <= 1'b1;
    predict_timer_op(k, id, to);
    do @(posedge clk); while (stall);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    valid <= 1'b0;
    while (pending_beats.size() != 0) @(negedge clk);
    repeat (60) @(negedge clk);
  endtask

  // Result checker: compares each accepted beat against the oldest prediction.
  always @(posedge clk) begin
    timer_beat_t got, want;
    if (!rst && out_valid && !out_stall) begin
      got = '{out_id, id_valid, fired, status, next_wait_ms, queue_empty, entry_count, last};
      if (pending_beats.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result beat %p", got);
      end else begin
        want = pending_beats.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("Mismatch: expected %p, got %p", want, got);
        end
      end
    end
  end

  // Receiver back-pressure, with calm stretches.
  always @(negedge clk) begin
    int r;
    r = $urandom_range(0, 99);
    if (!stall_busy) out_stall <= 1'b0;
    else if (r < 70) out_stall <= 1'b0;
    else if (r < 97) out_stall <= 1'b1;
    else out_stall <= ($urandom_range(0, 1) == 1);
    if ($urandom_range(0, 199) == 0) stall_busy <= ~stall_busy;
  end

  // Watchdog.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic test_directed_edges();
    send_op(KIND_POP, 8'd0, '0);
    send_op(KIND_ADJUST, 8'd7, 24'd5);
    send_op(KIND_TICK, 8'd0, '0);
    send_op(KIND_ADD, 8'd0, '0);
    send_op(KIND_ADD, 8'd255, 24'hFFFFFF);
    send_op(KIND_ADD, 8'd10, 24'd2);
    send_op(KIND_ADD, 8'd11, 24'd2);
    send_op(KIND_ADD, 8'd10, 24'd3);
    send_op(KIND_ADJUST, 8'd255, 24'd1);
    send_op(KIND_TICK, 8'd0, '0);
    send_op(KIND_TICK, 8'd0, '0);
    send_op(KIND_POP, 8'd0, '0);
    send_op(3'd5, 8'hAA, 24'h555555);
    send_op(3'd6, 8'h55, 24'hAAAAAA);
    send_op(3'd7, 8'd0, '0);
    send_op(KIND_CLEAR, 8'd0, '0);
    send_op(KIND_POP, 8'd0, '0);
  endtask

  // Fills the heap, overflows it, refreshes while full, then fires all at once.
  task automatic test_full_and_burst();
    for (int i = 0; i < CAP; i++) send_op(KIND_ADD, 8'(i * 7 + 1), 24'd1);
    send_op(KIND_ADD, 8'd200, 24'd4);
    send_op(KIND_ADD, 8'd8, 24'd1);
    send_op(KIND_TICK, 8'd0, '0);
    send_op(KIND_TICK, 8'd0, '0);
  endtask

  task automatic test_random_mix();
    int r;
    logic [TO_W-1:0] to;
    logic [ID_W-1:0] id;
    for (int i = 0; i < 320; i++) begin
      r = $urandom_range(0, 99);
      id = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 40));
      case ($urandom_range(0, 9))
        0: to = 24'($urandom);
        1: to = 24'hFFFFFF;
        default: to = 24'($urandom_range(0, 6));
      endcase
      if (r < 35) send_op(KIND_ADD, id, to);
      else if (r < 50) send_op(KIND_ADJUST, id, to);
      else if (r < 60) send_op(KIND_POP, id, to);
      else if (r < 62) send_op(KIND_CLEAR, id, to);
      else if (r < 97) send_op(KIND_TICK, id, to);
      else send_op(3'($urandom_range(5, 7)), id, to);
    end
  endtask

  initial begin
    n_timers = 0;
    clock_ms = '0;
    foreach (armed[i]) armed[i] = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed_edges();
    test_full_and_burst();
    test_random_mix();
    wait_drained();
    if (mismatches == 0 && pending_beats.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// File: sim.f
sv/mhtq_pkg.sv
sv/mhtq_ram.sv
sv/min_heap_timeout_queue_core.sv
sim/min_heap_timeout_queue_core_tb.sv
